/* sv/csv_field_splitter_unit_assert.svh */
// Assertion helpers for the splitter RTL, included by the back end.
`ifndef CSV_FIELD_SPLITTER_UNIT_ASSERT_SVH
`define CSV_FIELD_SPLITTER_UNIT_ASSERT_SVH

// Property that must hold on every clock edge outside reset.
`define CSVFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Antecedent this cycle implies consequent on the next edge.
`define CSVFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/csvfs_pkg.sv */
`default_nettype none

package csvfs_pkg;

    // parse mode of the back end
    typedef enum logic [2:0] {
        MODE_START    = 3'd0,
        MODE_UNQUOTED = 3'd1,
        MODE_QUOTED   = 3'd2,
        MODE_QSEEN    = 3'd3,
        MODE_DROP     = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_LONE_QUOTE = 2'd1,
        ERR_BARE_QUOTE = 2'd2,
        ERR_JUNK_QUOTE = 2'd3
    } err_t;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_DELIM = 1'b0,
        REG_QUOTE = 1'b1
    } reg_idx_t;

    localparam int          APB_ADDR_W  = 3;
    localparam logic [7:0]  QUOTE_OFF   = 8'h00;
    localparam logic [7:0]  DELIM_RESET = 8'd44;
    localparam logic [7:0]  QUOTE_RESET = 8'd34;

    // classified input beat as held in the queue
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       is_quote;
        logic       is_delim;
    } beat_t;

endpackage

`default_nettype wire

/* sv/csvfs_front.sv */
`default_nettype none

module csvfs_front (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [csvfs_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    input  wire logic [7:0]                       in_data,
    input  wire logic                             in_last,
    output csvfs_pkg::beat_t                      beat
);
    import csvfs_pkg::*;

    logic [7:0] delim_reg;
    logic [7:0] quote_reg;
    reg_idx_t   reg_sel;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg <= DELIM_RESET;
            quote_reg <= QUOTE_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                REG_DELIM: delim_reg <= pwdata[7:0];
                REG_QUOTE: quote_reg <= pwdata[7:0];
                default:   delim_reg <= delim_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_DELIM: prdata = {24'b0, delim_reg};
            REG_QUOTE: prdata = {24'b0, quote_reg};
            default:   prdata = 32'b0;
        endcase
    end

    // classify against the current registers; quote 0 means quoting off
    always_comb begin
        beat.data     = in_data;
        beat.last     = in_last;
        beat.is_quote = (quote_reg != QUOTE_OFF) && (in_data == quote_reg);
        beat.is_delim = (in_data == delim_reg);
    end

endmodule

`default_nettype wire

/* sv/csvfs_queue.sv */
`default_nettype none

module csvfs_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire csvfs_pkg::beat_t push_beat,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output csvfs_pkg::beat_t      pop_beat
);
    import csvfs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    beat_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_beat   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_beat;
        end
    end

endmodule

`default_nettype wire

/* sv/csvfs_back.sv */
`default_nettype none

module csvfs_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire csvfs_pkg::beat_t  in_beat,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             out_byte,
    output logic                   byte_valid,
    output logic                   field_end,
    output logic                   record_end,
    output csvfs_pkg::err_t        error_code
);
    import csvfs_pkg::*;

    mode_t      mode_reg, mode_next;
    logic       out_valid_reg;
    logic [7:0] obyte_reg, obyte_next;
    logic       valid_reg, valid_next;
    logic       fend_reg, fend_next;
    logic       rend_reg;
    err_t       err_reg, err_next;
    logic       pop;

    // output slot frees when empty or being taken
    assign in_ready = !out_valid_reg || out_ready;
    assign pop      = in_valid && in_ready;

    always_comb begin
        mode_next  = mode_reg;
        obyte_next = 8'h00;
        valid_next = 1'b0;
        fend_next  = 1'b0;
        err_next   = ERR_NONE;
        case (mode_reg)
            MODE_UNQUOTED: begin
                if (in_beat.is_delim) begin
                    fend_next = 1'b1;
                    mode_next = MODE_START;
                end else if (in_beat.is_quote) begin
                    err_next  = ERR_BARE_QUOTE;
                    mode_next = MODE_DROP;
                end else begin
                    obyte_next = in_beat.data;
                    valid_next = 1'b1;
                    mode_next  = MODE_UNQUOTED;
                end
            end
            MODE_QUOTED: begin
                if (in_beat.is_quote) begin
                    mode_next = MODE_QSEEN;
                end else begin
                    obyte_next = in_beat.data;
                    valid_next = 1'b1;
                    mode_next  = MODE_QUOTED;
                end
            end
            MODE_QSEEN: begin
                if (in_beat.is_delim) begin
                    fend_next = 1'b1;
                    mode_next = MODE_START;
                end else if (in_beat.is_quote) begin
                    // doubled quote
                    obyte_next = in_beat.data;
                    valid_next = 1'b1;
                    mode_next  = MODE_QUOTED;
                end else begin
                    err_next  = ERR_JUNK_QUOTE;
                    mode_next = MODE_DROP;
                end
            end
            MODE_DROP: begin
                mode_next = MODE_DROP;
            end
            default: begin
                // field start
                if (in_beat.is_quote) begin
                    if (in_beat.last) begin
                        err_next = ERR_LONE_QUOTE;
                    end
                    mode_next = MODE_QUOTED;
                end else if (in_beat.is_delim) begin
                    fend_next = 1'b1;
                    mode_next = MODE_START;
                end else begin
                    obyte_next = in_beat.data;
                    valid_next = 1'b1;
                    mode_next  = MODE_UNQUOTED;
                end
            end
        endcase

        if (in_beat.last) begin
            if (err_next == ERR_NONE && mode_next != MODE_START && mode_next != MODE_DROP) begin
                fend_next = 1'b1;
            end
            mode_next = MODE_START;
        end
        if (err_next != ERR_NONE) begin
            fend_next  = 1'b0;
            valid_next = 1'b0;
            obyte_next = 8'h00;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_START;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                mode_reg <= mode_next;
            end
            if (in_ready) begin
                out_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            obyte_reg <= obyte_next;
            valid_reg <= valid_next;
            fend_reg  <= fend_next;
            rend_reg  <= in_beat.last;
            err_reg   <= err_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = obyte_reg;
    assign byte_valid = valid_reg;
    assign field_end  = fend_reg;
    assign record_end = rend_reg;
    assign error_code = err_reg;

`include "csv_field_splitter_unit_assert.svh"

    `CSVFS_ASSERT(a_err_no_content,
        !out_valid_reg || err_reg == ERR_NONE || (!valid_reg && !fend_reg),
        "error beat carries content or field end")
    `CSVFS_ASSERT(a_idle_byte_zero,
        !out_valid_reg || valid_reg || obyte_reg == 8'h00,
        "out_byte not zero without byte_valid")
    `CSVFS_ASSERT_NEXT(a_record_resets_mode,
        pop && in_beat.last, mode_reg == MODE_START,
        "mode not back at field start after record end")
    `CSVFS_ASSERT_NEXT(a_drop_silent,
        pop && mode_reg == MODE_DROP, !valid_reg && !fend_reg && err_reg == ERR_NONE,
        "dropped byte produced output")

endmodule

`default_nettype wire

/* sv/csv_field_splitter_unit.sv */
// CSV field splitter: one record byte in per beat, one result beat out per byte.
// Input stream s_*: tdata[7:0] is the record byte, tlast flags the record's last byte.
// Result stream m_*: tdata[7:0] unescaped content byte (zero when none), tdata[8]
//   field end; tuser[0] content byte present, tuser[2:1] error code
//   (0 ok, 1 lone opening quote, 2 quote in unquoted field, 3 junk after quote);
//   tlast marks the record's last beat.
// APB port: delimiter at byte address 0 (reset comma), quote at 4 (reset double
//   quote, zero turns quoting off). Only paddr[2] decodes. Write while idle.
// Throughput: one beat per cycle, sustained; the parse mode update is combinational
//   logic in the back end, so nothing stalls the stream but the sink.
// Path: an accepted beat passes the queue memory and the back end output register to m_*.
// The front end classifies and pushes into a small queue; the back end parses
//   and owns the output register, so each side stalls independently.
// Reset (aresetn low, synchronous): queue empties, m_tvalid drops, parse mode
//   returns to field start, registers return to comma and double quote.
// If the sink holds m_tready low, the result holds; the queue absorbs up to
//   QUEUE_DEPTH more beats before s_tready falls.
`default_nettype none

module csv_field_splitter_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // config
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [csvfs_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    // input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,   // [7:0] data_byte
    input  wire logic                             s_tlast,   // last_in_record
    // result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [15:0]                           m_tdata,   // [7:0] out_byte, [8] field_end
    output logic [2:0]                            m_tuser,   // [0] byte_valid, [2:1] error_code
    output logic                                  m_tlast    // record_end
);
    import csvfs_pkg::*;

    beat_t      front_beat;
    beat_t      queue_beat;
    logic       queue_valid;
    logic       queue_ready;
    logic [7:0] res_byte;
    logic       res_byte_valid;
    logic       res_field_end;
    err_t       res_err;

    // front: config registers and byte classification
    csvfs_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_data (s_tdata),
        .in_last (s_tlast),
        .beat    (front_beat)
    );

    // decoupling queue between classifier and parser
    csvfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_beat  (front_beat),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_beat   (queue_beat)
    );

    // back: parse mode and registered result
    csvfs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (queue_valid),
        .in_ready   (queue_ready),
        .in_beat    (queue_beat),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (res_byte),
        .byte_valid (res_byte_valid),
        .field_end  (res_field_end),
        .record_end (m_tlast),
        .error_code (res_err)
    );

    assign m_tdata = {7'b0, res_field_end, res_byte};
    assign m_tuser = {res_err, res_byte_valid};

endmodule

`default_nettype wire
